// ----- design/sfts_pkg.sv -----
package sfts_pkg;

    localparam int SEGMENT_BYTES = 256;
    localparam int MAX_SEGMENTS  = 768;
    localparam int SEG_SHIFT     = $clog2(SEGMENT_BYTES);
    localparam int IMAGE_LIMIT   = SEGMENT_BYTES * MAX_SEGMENTS;

    localparam int SIZE_W  = 18;
    localparam int CRC_W   = 32;
    localparam int SEQ_W   = 16;
    localparam int SEG_W   = 10;
    localparam int LEN_W   = 9;
    localparam int TICK_W  = 20;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 4;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_ACK  = 2'd1;
    localparam logic [1:0] ACT_FILE = 2'd2;

    localparam logic [1:0] FS_UNKNOWN  = 2'd0;
    localparam logic [1:0] FS_WRITING  = 2'd1;
    localparam logic [1:0] FS_FINISHED = 2'd2;

    localparam logic [1:0] SEND_NONE    = 2'd0;
    localparam logic [1:0] SEND_CLEAR   = 2'd1;
    localparam logic [1:0] SEND_START   = 2'd2;
    localparam logic [1:0] SEND_SEGMENT = 2'd3;

    localparam logic [1:0] REG_SLOT    = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_PAUSE   = 2'd2;

    localparam logic [TICK_W-1:0] SLOT_RESET    = TICK_W'(2);
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(4000);
    localparam logic [TICK_W-1:0] PAUSE_RESET   = TICK_W'(10 * 60 * 1000);

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_CLEAR      = 3'd1,
        PH_CLEAR_WAIT = 3'd2,
        PH_START      = 3'd3,
        PH_START_WAIT = 3'd4,
        PH_SEG        = 3'd5,
        PH_SEG_WAIT   = 3'd6,
        PH_PAUSE      = 3'd7
    } t_phase;

    typedef struct packed {
        logic [1:0]        action;
        logic              file_ok;
        logic [SIZE_W-1:0] file_size;
        logic [CRC_W-1:0]  checked_crc;
        logic [SEQ_W-1:0]  next_seq;
        logic              queue_ready;
        logic [SEQ_W-1:0]  ack_seq;
        logic              ack_ok;
        logic [1:0]        new_file_state;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        send_kind;
        logic [SEQ_W-1:0]  send_seq;
        logic [SEG_W-1:0]  segment_number;
        logic [LEN_W-1:0]  segment_length;
        logic [SIZE_W-1:0] image_size;
        logic [CRC_W-1:0]  image_crc;
        logic [SEG_W-1:0]  segment_count;
        logic              ack_matched;
        logic              update_failed;
        logic [2:0]        phase_now;
    } t_out_item;

    typedef struct packed {
        logic [TICK_W-1:0] slot_ticks;
        logic [TICK_W-1:0] ack_timeout_ticks;
        logic [TICK_W-1:0] retry_pause_ticks;
    } t_cfg;

endpackage

// ----- design/sfts_regs.sv -----
module sfts_regs import sfts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic [1:0] w_index;
    logic       w_write;

    assign w_index = paddr[APB_AW-1:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slot_ticks        <= SLOT_RESET;
            r_cfg.ack_timeout_ticks <= TIMEOUT_RESET;
            r_cfg.retry_pause_ticks <= PAUSE_RESET;
        end else if (w_write) begin
            unique case (w_index)
                REG_SLOT:    r_cfg.slot_ticks        <= pwdata[TICK_W-1:0];
                REG_TIMEOUT: r_cfg.ack_timeout_ticks <= pwdata[TICK_W-1:0];
                REG_PAUSE:   r_cfg.retry_pause_ticks <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            REG_SLOT:    prdata = APB_DW'(r_cfg.slot_ticks);
            REG_TIMEOUT: prdata = APB_DW'(r_cfg.ack_timeout_ticks);
            REG_PAUSE:   prdata = APB_DW'(r_cfg.retry_pause_ticks);
            default:     prdata = '0;
        endcase
    end

endmodule

// ----- design/sfts_engine.sv -----
module sfts_engine import sfts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    t_phase            r_phase,     n_phase;
    logic [1:0]        r_fstate,    n_fstate;
    logic [SEQ_W-1:0]  r_out_seq,   n_out_seq;
    logic              r_acked,     n_acked;
    logic [SEG_W-1:0]  r_seg_index, n_seg_index;
    logic [SEG_W-1:0]  r_seg_total, n_seg_total;
    logic [SIZE_W-1:0] r_size,      n_size;
    logic [CRC_W-1:0]  r_crc,       n_crc;
    logic [TICK_W-1:0] r_timer,     n_timer;
    logic              r_fail,      n_fail;

    logic [TICK_W-1:0] w_timer_dec;
    logic              w_expired;
    logic [SIZE_W:0]   w_rounded;
    logic              w_fits;
    logic [SIZE_W-1:0] w_seg_start;
    logic [SIZE_W-1:0] w_seg_remain;
    logic [LEN_W-1:0]  w_seg_len;
    t_out_item         w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_fstate    <= FS_UNKNOWN;
            r_out_seq   <= '0;
            r_acked     <= 1'b0;
            r_seg_index <= '0;
            r_seg_total <= '0;
            r_size      <= '0;
            r_crc       <= '0;
            r_timer     <= '0;
            r_fail      <= 1'b0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_fstate    <= n_fstate;
            r_out_seq   <= n_out_seq;
            r_acked     <= n_acked;
            r_seg_index <= n_seg_index;
            r_seg_total <= n_seg_total;
            r_size      <= n_size;
            r_crc       <= n_crc;
            r_timer     <= n_timer;
            r_fail      <= n_fail;
        end
    end

    assign w_timer_dec  = (r_timer != '0) ? r_timer - TICK_W'(1) : '0;
    assign w_expired    = (w_timer_dec == '0);
    assign w_rounded    = {1'b0, i_item.file_size} + (SIZE_W + 1)'(SEGMENT_BYTES - 1);
    assign w_fits       = ({1'b0, i_item.file_size} <= (SIZE_W + 1)'(IMAGE_LIMIT));
    assign w_seg_start  = SIZE_W'({r_seg_index, {SEG_SHIFT{1'b0}}});
    assign w_seg_remain = r_size - w_seg_start;
    assign w_seg_len    = (w_seg_remain > SIZE_W'(SEGMENT_BYTES)) ? LEN_W'(SEGMENT_BYTES)
                                                                  : w_seg_remain[LEN_W-1:0];

    always_comb begin
        n_phase     = r_phase;
        n_fstate    = r_fstate;
        n_out_seq   = r_out_seq;
        n_acked     = r_acked;
        n_seg_index = r_seg_index;
        n_seg_total = r_seg_total;
        n_size      = r_size;
        n_crc       = r_crc;
        n_timer     = r_timer;
        n_fail      = r_fail;
        w_res       = '0;

        case (i_item.action)
            ACT_TICK: begin
                n_timer = w_timer_dec;
                unique case (r_phase)
                    PH_IDLE: begin
                        if (r_fstate == FS_UNKNOWN || r_fstate == FS_FINISHED) begin
                            if (i_item.file_ok && w_fits) begin
                                n_size      = i_item.file_size;
                                n_crc       = i_item.checked_crc;
                                n_seg_total = w_rounded[SEG_SHIFT +: SEG_W];
                                n_seg_index = '0;
                                n_phase     = PH_CLEAR;
                                n_fstate    = FS_FINISHED;
                                n_timer     = i_cfg.slot_ticks;
                            end else begin
                                n_fstate = FS_WRITING;
                                n_fail   = 1'b0;
                            end
                        end
                    end
                    PH_CLEAR, PH_START: begin
                        if (w_expired) begin
                            n_acked   = 1'b0;
                            n_out_seq = i_item.next_seq;
                            n_timer   = i_cfg.ack_timeout_ticks;
                            if (i_item.queue_ready) begin
                                w_res.send_seq = i_item.next_seq;
                                if (r_phase == PH_CLEAR) begin
                                    w_res.send_kind = SEND_CLEAR;
                                    n_phase         = PH_CLEAR_WAIT;
                                end else begin
                                    w_res.send_kind     = SEND_START;
                                    w_res.image_size    = r_size;
                                    w_res.image_crc     = r_crc;
                                    w_res.segment_count = r_seg_total;
                                    n_phase             = PH_START_WAIT;
                                end
                            end
                        end
                    end
                    PH_SEG: begin
                        if (w_expired) begin
                            if (r_seg_index >= r_seg_total) begin
                                n_phase  = PH_IDLE;
                                n_fstate = FS_WRITING;
                                n_fail   = 1'b0;
                            end else begin
                                n_acked   = 1'b0;
                                n_out_seq = i_item.next_seq;
                                n_timer   = i_cfg.ack_timeout_ticks;
                                if (i_item.queue_ready) begin
                                    w_res.send_kind      = SEND_SEGMENT;
                                    w_res.send_seq       = i_item.next_seq;
                                    w_res.segment_number = r_seg_index;
                                    w_res.segment_length = w_seg_len;
                                    n_seg_index          = r_seg_index + SEG_W'(1);
                                    n_phase              = PH_SEG_WAIT;
                                end
                            end
                        end
                    end
                    PH_CLEAR_WAIT, PH_START_WAIT, PH_SEG_WAIT: begin
                        if (r_acked) begin
                            n_phase = (r_phase == PH_CLEAR_WAIT) ? PH_START : PH_SEG;
                            n_timer = i_cfg.slot_ticks;
                        end else if (w_expired) begin
                            n_phase  = PH_PAUSE;
                            n_fstate = FS_FINISHED;
                            n_fail   = 1'b1;
                            n_timer  = i_cfg.retry_pause_ticks;
                        end
                    end
                    PH_PAUSE: begin
                        if (w_expired) begin
                            n_phase  = PH_IDLE;
                            n_fstate = FS_FINISHED;
                        end
                    end
                endcase
            end
            ACT_ACK: begin
                if (i_item.ack_ok && (i_item.ack_seq == r_out_seq)) begin
                    n_acked           = 1'b1;
                    w_res.ack_matched = 1'b1;
                end
            end
            ACT_FILE: begin
                if (i_item.new_file_state != r_fstate) begin
                    n_fstate = i_item.new_file_state;
                    n_phase  = PH_IDLE;
                    n_fail   = 1'b0;
                end
            end
            default: ;
        endcase

        w_res.update_failed = n_fail;
        w_res.phase_now     = n_phase;
    end

    assign o_result = w_res;

endmodule

// ----- design/segmented_file_transfer_sequencer_unit.sv -----
// Stop-and-wait image transfer sequencer. Each input item (a millisecond tick, an acknowledge
// or a file state change) yields exactly one result item that reports the frame issued, if
// any, the acknowledge match, the sticky failure flag and the phase. Items pass through an
// input register and a result register; the sequencer state is updated as an item moves to
// the result register, so one item is taken every clock unless i_out_ready stalls it. The
// three tick counts are set through the APB port at byte addresses 0, 4 and 8.
module segmented_file_transfer_sequencer_unit import sfts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      w_advance;
    t_cfg      w_cfg;
    t_out_item w_result;

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_item <= w_result;
        end
    end

    sfts_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sfts_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

endmodule

// ----- design/sfts_checker.sv -----
module sfts_checker import sfts_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input t_out_item         o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    a_send_enters_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.send_kind != SEND_NONE) |->
            (o_out_item.phase_now == PH_CLEAR_WAIT) || (o_out_item.phase_now == PH_START_WAIT)
            || (o_out_item.phase_now == PH_SEG_WAIT))
        else $error("frame issued without entering a wait phase");

    a_ack_no_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.ack_matched |-> (o_out_item.send_kind == SEND_NONE))
        else $error("acknowledge item also issued a frame");

    a_seg_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.send_kind == SEND_SEGMENT) |->
            (o_out_item.segment_length != '0)
            && (o_out_item.segment_length <= LEN_W'(SEGMENT_BYTES)))
        else $error("segment length out of range");

endmodule

bind segmented_file_transfer_sequencer_unit sfts_checker u_sfts_checker (.*);

// ----- verif/testbench.sv -----
module testbench;
    import sfts_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [1:0] FS_OTHER   = 2'd3;
    localparam int RANDOM_ITEMS_PER_PHASE = 350;
    localparam int RUN_LIMIT = 2_000_000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_item = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out_item;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    segmented_file_transfer_sequencer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // Predicted sequencer state, kept in step with every accepted item.
    t_cfg               m_cfg;
    t_phase             m_phase;
    logic [1:0]         m_file_state;
    logic [SEQ_W-1:0]   m_outstanding;
    logic               m_acked;
    logic [SEG_W-1:0]   m_seg_index;
    logic [SEG_W-1:0]   m_seg_total;
    logic [SIZE_W-1:0]  m_size;
    logic [CRC_W-1:0]   m_crc;
    logic [TICK_W-1:0]  m_timer;
    logic               m_fail;

    int frames_issued = 0;
    int images_sent = 0;
    int ack_timeouts = 0;
    int items_taken = 0;
    int results_checked = 0;
    int error_count = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int out_hold_cycles = 0;

    t_out_item predicted_results[$];

    function automatic t_out_item step_sequencer(input t_in_item it);
        t_out_item   r;
        logic        expired;
        int unsigned seg_base;
        int unsigned seg_len;
        r = '0;
        case (it.action)
            ACT_TICK: begin
                if (m_timer != '0)
                    m_timer = m_timer - 1'b1;
                expired = (m_timer == '0);
                case (m_phase)
                    PH_IDLE: begin
                        if (m_file_state == FS_UNKNOWN || m_file_state == FS_FINISHED) begin
                            if (it.file_ok && it.file_size <= IMAGE_LIMIT) begin
                                m_size       = it.file_size;
                                m_crc        = it.checked_crc;
                                m_seg_total  = SEG_W'((32'(it.file_size) + SEGMENT_BYTES - 1)
                                                      / SEGMENT_BYTES);
                                m_seg_index  = '0;
                                m_phase      = PH_CLEAR;
                                m_file_state = FS_FINISHED;
                                m_timer      = m_cfg.slot_ticks;
                            end else begin
                                m_file_state = FS_WRITING;
                                m_fail       = 1'b0;
                            end
                        end
                    end
                    PH_CLEAR, PH_START: begin
                        if (expired) begin
                            m_acked       = 1'b0;
                            m_outstanding = it.next_seq;
                            if (it.queue_ready) begin
                                r.send_seq = it.next_seq;
                                if (m_phase == PH_CLEAR) begin
                                    r.send_kind = SEND_CLEAR;
                                    m_phase     = PH_CLEAR_WAIT;
                                end else begin
                                    r.send_kind     = SEND_START;
                                    r.image_size    = m_size;
                                    r.image_crc     = m_crc;
                                    r.segment_count = m_seg_total;
                                    m_phase         = PH_START_WAIT;
                                end
                            end
                            m_timer = m_cfg.ack_timeout_ticks;
                        end
                    end
                    PH_SEG: begin
                        if (expired) begin
                            if (m_seg_index >= m_seg_total) begin
                                m_phase      = PH_IDLE;
                                m_file_state = FS_WRITING;
                                m_fail       = 1'b0;
                                images_sent++;
                            end else begin
                                m_acked       = 1'b0;
                                m_outstanding = it.next_seq;
                                if (it.queue_ready) begin
                                    seg_base = m_seg_index * SEGMENT_BYTES;
                                    seg_len  = m_size - seg_base;
                                    if (seg_len > SEGMENT_BYTES)
                                        seg_len = SEGMENT_BYTES;
                                    r.send_kind      = SEND_SEGMENT;
                                    r.send_seq       = it.next_seq;
                                    r.segment_number = m_seg_index;
                                    r.segment_length = LEN_W'(seg_len);
                                    m_seg_index      = m_seg_index + 1'b1;
                                    m_phase          = PH_SEG_WAIT;
                                end
                                m_timer = m_cfg.ack_timeout_ticks;
                            end
                        end
                    end
                    PH_CLEAR_WAIT, PH_START_WAIT, PH_SEG_WAIT: begin
                        if (!m_acked) begin
                            if (expired) begin
                                m_phase      = PH_PAUSE;
                                m_file_state = FS_FINISHED;
                                m_fail       = 1'b1;
                                m_timer      = m_cfg.retry_pause_ticks;
                                ack_timeouts++;
                            end
                        end else begin
                            m_phase = (m_phase == PH_CLEAR_WAIT) ? PH_START : PH_SEG;
                            m_timer = m_cfg.slot_ticks;
                        end
                    end
                    default: begin
                        if (expired) begin
                            m_phase      = PH_IDLE;
                            m_file_state = FS_FINISHED;
                        end
                    end
                endcase
            end
            ACT_ACK: begin
                if (it.ack_ok && it.ack_seq == m_outstanding) begin
                    m_acked       = 1'b1;
                    r.ack_matched = 1'b1;
                end
            end
            ACT_FILE: begin
                if (it.new_file_state != m_file_state) begin
                    m_file_state = it.new_file_state;
                    m_phase      = PH_IDLE;
                    m_fail       = 1'b0;
                end
            end
            default: ;
        endcase
        if (r.send_kind != SEND_NONE)
            frames_issued++;
        r.update_failed = m_fail;
        r.phase_now     = m_phase;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= 100)
            $display("MISMATCH result %0d %s: got %0h, predicted %0h at %0t",
                     results_checked, what, got, want, $time);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predicted_results.push_back(step_sequencer(i_in_item));
                items_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("result with none pending", 32'(o_out_item.phase_now),
                                    '0);
                end else begin
                    want = predicted_results.pop_front();
                    check_field("send_kind", 32'(o_out_item.send_kind), 32'(want.send_kind));
                    check_field("send_seq", 32'(o_out_item.send_seq), 32'(want.send_seq));
                    check_field("segment_number", 32'(o_out_item.segment_number),
                                32'(want.segment_number));
                    check_field("segment_length", 32'(o_out_item.segment_length),
                                32'(want.segment_length));
                    check_field("image_size", 32'(o_out_item.image_size),
                                32'(want.image_size));
                    check_field("image_crc", o_out_item.image_crc, want.image_crc);
                    check_field("segment_count", 32'(o_out_item.segment_count),
                                32'(want.segment_count));
                    check_field("ack_matched", 32'(o_out_item.ack_matched),
                                32'(want.ack_matched));
                    check_field("update_failed", 32'(o_out_item.update_failed),
                                32'(want.update_failed));
                    check_field("phase_now", 32'(o_out_item.phase_now), 32'(want.phase_now));
                end
                results_checked++;
            end
        end
    end

    // The receiver counts down a requested hold-off before it resumes random stalls.
    always @(negedge i_clk) begin
        if (out_hold_cycles > 0) begin
            i_out_ready = 1'b0;
            out_hold_cycles = out_hold_cycles - 1;
        end else begin
            i_out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct)
            @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_item  = it;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic drain_results();
        while (predicted_results.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (index)
            REG_SLOT:    m_cfg.slot_ticks        = value[TICK_W-1:0];
            REG_TIMEOUT: m_cfg.ack_timeout_ticks = value[TICK_W-1:0];
            REG_PAUSE:   m_cfg.retry_pause_ticks = value[TICK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_timers(input logic [31:0] slot, input logic [31:0] timeout,
                              input logic [31:0] pause);
        drain_results();
        write_reg(REG_SLOT, slot);
        write_reg(REG_TIMEOUT, timeout);
        write_reg(REG_PAUSE, pause);
    endtask

    function automatic t_in_item random_bits();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    function automatic t_in_item tick_item(input logic ok, input logic [SIZE_W-1:0] size,
                                           input logic [CRC_W-1:0] crc,
                                           input logic [SEQ_W-1:0] seq, input logic qready);
        t_in_item it;
        it             = random_bits();
        it.action      = ACT_TICK;
        it.file_ok     = ok;
        it.file_size   = size;
        it.checked_crc = crc;
        it.next_seq    = seq;
        it.queue_ready = qready;
        return it;
    endfunction

    function automatic t_in_item ack_item(input logic [SEQ_W-1:0] seq, input logic ok);
        t_in_item it;
        it         = random_bits();
        it.action  = ACT_ACK;
        it.ack_seq = seq;
        it.ack_ok  = ok;
        return it;
    endfunction

    function automatic t_in_item file_item(input logic [1:0] state);
        t_in_item it;
        it                = random_bits();
        it.action         = ACT_FILE;
        it.new_file_state = state;
        return it;
    endfunction

    function automatic logic awaiting_ack();
        return (m_phase == PH_CLEAR_WAIT || m_phase == PH_START_WAIT ||
                m_phase == PH_SEG_WAIT) && !m_acked;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 19))
            0:       return $urandom_range(0, 1) ? SIZE_W'(IMAGE_LIMIT)
                                                 : SIZE_W'(IMAGE_LIMIT + 1);
            1:       return SIZE_W'($urandom);
            2, 3:    return SIZE_W'(SEGMENT_BYTES * $urandom_range(0, 6));
            default: return SIZE_W'($urandom_range(0, 1500));
        endcase
    endfunction

    // Mostly well-formed transfer traffic steered by the predicted phase, with noise mixed in.
    function automatic t_in_item make_random_item();
        t_in_item it;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return random_bits();
        it = tick_item($urandom_range(0, 9) != 0, pick_size(), $urandom, SEQ_W'($urandom),
                       $urandom_range(0, 7) != 0);
        if (awaiting_ack() && pick < 60) begin
            it = ack_item(($urandom_range(0, 9) != 0) ? m_outstanding : SEQ_W'($urandom),
                          $urandom_range(0, 9) != 0);
        end else if (m_phase == PH_IDLE && pick < 70 &&
                     (m_file_state == FS_WRITING || m_file_state == FS_OTHER)) begin
            it = file_item($urandom_range(0, 1) ? FS_FINISHED : FS_UNKNOWN);
        end else if (pick >= 94) begin
            it = file_item(2'($urandom));
        end else if (pick >= 91) begin
            it = ack_item($urandom_range(0, 1) ? m_outstanding : SEQ_W'($urandom),
                          1'($urandom));
        end
        return it;
    endfunction

    task automatic test_directed();
        t_in_item it;
        it = random_bits();
        it.action = ACT_UNUSED;
        send_item(it);
        send_item(ack_item(16'h0000, 1'b1));
        send_item(tick_item(1'b1, SIZE_W'(IMAGE_LIMIT + 1), $urandom, SEQ_W'($urandom), 1'b1));
        send_item(file_item(FS_FINISHED));
        send_item(tick_item(1'b0, 18'd100, $urandom, SEQ_W'($urandom), 1'b1));
        send_item(file_item(FS_OTHER));
        send_item(tick_item(1'b1, 18'd10, $urandom, SEQ_W'($urandom), 1'b1));
        set_timers(1, 1, 1);
        send_item(file_item(FS_UNKNOWN));
        send_item(tick_item(1'b1, 18'd300, 32'hFFFF_FFFF, SEQ_W'($urandom), 1'b1));
        send_item(tick_item(1'b0, SIZE_W'($urandom), $urandom, 16'h1234, 1'b0));
        send_item(tick_item(1'b0, SIZE_W'($urandom), $urandom, 16'hFFFF, 1'b1));
        send_item(ack_item(16'hFFFF, 1'b0));
        send_item(ack_item(16'hFFFF, 1'b1));
        send_item(tick_item(1'b0, SIZE_W'($urandom), $urandom, SEQ_W'($urandom), 1'b1));
        send_item(tick_item(1'b0, SIZE_W'($urandom), $urandom, 16'h0000, 1'b1));
        send_item(ack_item(16'h0000, 1'b1));
        for (int s = 5; s < 7; s++) begin
            send_item(tick_item(1'b0, SIZE_W'($urandom), $urandom, SEQ_W'($urandom), 1'b1));
            send_item(tick_item(1'b0, SIZE_W'($urandom), $urandom, SEQ_W'(s), 1'b1));
            send_item(ack_item(SEQ_W'(s), 1'b1));
        end
        send_item(tick_item(1'b0, SIZE_W'($urandom), $urandom, SEQ_W'($urandom), 1'b1));
        send_item(tick_item(1'b0, SIZE_W'($urandom), $urandom, SEQ_W'($urandom), 1'b1));
        // An empty image whose clear command is never acknowledged times out into the pause.
        send_item(file_item(FS_FINISHED));
        send_item(tick_item(1'b1, 18'd0, 32'h0000_0000, SEQ_W'($urandom), 1'b1));
        repeat (3) begin
            send_item(tick_item(1'b1, SIZE_W'($urandom), $urandom, SEQ_W'($urandom), 1'b1));
        end
    endtask

    task automatic test_long_image();
        set_timers(0, 3, 0);
        send_item(file_item(FS_WRITING));
        send_item(file_item(FS_FINISHED));
        send_item(tick_item(1'b1, 18'd25000, $urandom, SEQ_W'($urandom), 1'b1));
        while (m_phase != PH_IDLE) begin
            if (awaiting_ack())
                send_item(ack_item(m_outstanding, 1'b1));
            else
                send_item(tick_item(1'b0, SIZE_W'($urandom), $urandom, SEQ_W'($urandom),
                                    1'b1));
        end
    endtask

    task automatic test_timer_extremes();
        set_timers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (40) send_item(make_random_item());
    endtask

    task automatic test_random_traffic();
        int idle_pct[4];
        int stall_pct[4];
        idle_pct  = '{0, 71, 0, 18};
        stall_pct = '{0, 0, 71, 18};
        for (int p = 0; p < 4; p++) begin
            if (p == 0)
                set_timers(0, 0, 0);
            else
                set_timers($urandom_range(0, 3), $urandom_range(1, 8), $urandom_range(0, 6));
            send_idle_pct  = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            repeat (RANDOM_ITEMS_PER_PHASE) send_item(make_random_item());
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_output_backpressure();
        set_timers(1, 4, 2);
        @(posedge i_clk);
        out_hold_cycles = 300;
        @(negedge i_clk);
        repeat (80) send_item(make_random_item());
        drain_results();
    endtask

    initial begin
        m_cfg.slot_ticks        = SLOT_RESET;
        m_cfg.ack_timeout_ticks = TIMEOUT_RESET;
        m_cfg.retry_pause_ticks = PAUSE_RESET;
        m_phase       = PH_IDLE;
        m_file_state  = FS_UNKNOWN;
        m_outstanding = '0;
        m_acked       = 1'b0;
        m_seg_index   = '0;
        m_seg_total   = '0;
        m_size        = '0;
        m_crc         = '0;
        m_timer       = '0;
        m_fail        = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_long_image();
        test_timer_extremes();
        test_random_traffic();
        test_output_backpressure();
        drain_results();
        repeat (6) @(posedge i_clk);
        $display("Covered %0d items and %0d results: %0d frames, %0d full images sent,",
                 items_taken, results_checked, frames_issued, images_sent);
        $display("%0d acknowledge timeouts, under default, minimum, maximum and random timers.",
                 ack_timeouts);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
